### design/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Types, codes and sizes shared by the sorted meter table modules.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 48;
  localparam int TERM_W      = 48;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_DEL     = 3'd1,
    ACT_LOOKUP  = 3'd2,
    ACT_SETTERM = 3'd3,
    ACT_COUNT   = 3'd4,
    ACT_FREE    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_SLOT     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [KEY_W-1:0]  meter_key;
    logic [7:0]        protocol_type;
    logic [TERM_W-1:0] terminal_addr;
    logic [7:0]        success_flag;
    logic [15:0]       slot_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_index;
    logic [7:0]  out_type;
    logic [47:0] out_terminal;
    logic [7:0]  out_flag;
    logic [7:0]  out_slot;
    logic [8:0]  match_count;
    logic [7:0]  free_slot;
    logic        free_found;
    logic [8:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [7:0]        ptype;
    logic [TERM_W-1:0] term;
    logic [7:0]        flag;
    logic [IDX_W-1:0]  slot;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SRCH_CMP,
    S_PROBE_CHK,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_MOVE,
    S_INS_PUT,
    S_DEL_CHK,
    S_DEL_MOVE,
    S_DEL_DONE,
    S_COUNT,
    S_FREE,
    S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_RD,
    OP_SRCH_UPD,
    OP_PROBE_RD,
    OP_PROBE_CHK,
    OP_MODIFY,
    OP_INS_INIT,
    OP_INS_RD,
    OP_INS_STEP,
    OP_INS_PUT,
    OP_DEL_INIT,
    OP_DEL_RD,
    OP_DEL_STEP,
    OP_DEL_DONE,
    OP_CNT_INIT,
    OP_CNT_STEP,
    OP_FREE_INIT,
    OP_FREE_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t res_status;
    logic    res_entry;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       found;
    logic       slot_bad;
    logic       full;
    logic       srch_go;
    logic       mv_any;
    logic       mv_more;
    logic       del_any;
    logic       del_more;
    logic       cnt_done;
    logic       free_done;
    logic       out_busy;
  } stat_t;

endpackage

### design/smt_if.sv
// ----------------------------------------------------------------------------
// smt_in_if / smt_out_if
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface smt_in_if;
  import smt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smt_out_if;
  import smt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl
// Sequencer: binary search, dispatch, entry moves, scans and result issue.
// ----------------------------------------------------------------------------
module smt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  smt_pkg::stat_t stat,
  output smt_pkg::cmd_t  cmd
);
  import smt_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;
  logic    res_entry_r, res_entry_nxt;

  // state and result code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_OK;
      res_entry_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_entry_r  <= res_entry_nxt;
    end
  end

  // next state and result code
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        state_nxt = stat.srch_go ? S_SRCH_CMP : S_PROBE_CHK;
      end
      S_SRCH_CMP: state_nxt = S_SEARCH;
      S_PROBE_CHK: state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        res_status_nxt = ST_OK;
        res_entry_nxt  = 1'b0;
        state_nxt      = S_EMIT;
        case (action_t'(stat.act))
          ACT_ADD: begin
            if (stat.slot_bad) begin
              res_status_nxt = ST_SLOT;
            end else if (stat.found) begin
              res_entry_nxt = 1'b1;
            end else if (stat.full) begin
              res_status_nxt = ST_FULL;
            end else begin
              res_entry_nxt = 1'b1;
              state_nxt     = S_INS_CHK;
            end
          end
          ACT_DEL: begin
            if (stat.found) begin
              res_entry_nxt = 1'b1;
              state_nxt     = S_DEL_CHK;
            end else begin
              res_status_nxt = ST_NOTFOUND;
            end
          end
          ACT_LOOKUP, ACT_SETTERM: begin
            if (stat.found) res_entry_nxt  = 1'b1;
            else            res_status_nxt = ST_NOTFOUND;
          end
          ACT_COUNT: state_nxt = S_COUNT;
          ACT_FREE:  state_nxt = S_FREE;
          default: ;
        endcase
      end
      S_INS_CHK:  state_nxt = stat.mv_any ? S_INS_MOVE : S_INS_PUT;
      S_INS_MOVE: state_nxt = stat.mv_more ? S_INS_MOVE : S_INS_PUT;
      S_INS_PUT:  state_nxt = S_EMIT;
      S_DEL_CHK:  state_nxt = stat.del_any ? S_DEL_MOVE : S_DEL_DONE;
      S_DEL_MOVE: state_nxt = stat.del_more ? S_DEL_MOVE : S_DEL_DONE;
      S_DEL_DONE: state_nxt = S_EMIT;
      S_COUNT: begin
        if (stat.cnt_done) state_nxt = S_EMIT;
      end
      S_FREE: begin
        if (stat.free_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_ready       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.res_status = res_status_r;
    cmd.res_entry  = res_entry_r;
    case (state_r)
      S_IDLE: begin
        // no item is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) cmd.op = OP_LOAD;
      end
      S_SEARCH:    cmd.op = stat.srch_go ? OP_SRCH_RD : OP_PROBE_RD;
      S_SRCH_CMP:  cmd.op = OP_SRCH_UPD;
      S_PROBE_CHK: cmd.op = OP_PROBE_CHK;
      S_DISPATCH: begin
        case (action_t'(stat.act))
          ACT_ADD: begin
            if (!stat.slot_bad && stat.found)                    cmd.op = OP_MODIFY;
            else if (!stat.slot_bad && !stat.found && !stat.full) cmd.op = OP_INS_INIT;
          end
          ACT_DEL:     if (stat.found) cmd.op = OP_DEL_INIT;
          ACT_SETTERM: if (stat.found) cmd.op = OP_MODIFY;
          ACT_COUNT:   cmd.op = OP_CNT_INIT;
          ACT_FREE:    cmd.op = OP_FREE_INIT;
          default: ;
        endcase
      end
      S_INS_CHK:  if (stat.mv_any) cmd.op = OP_INS_RD;
      S_INS_MOVE: cmd.op = OP_INS_STEP;
      S_INS_PUT:  cmd.op = OP_INS_PUT;
      S_DEL_CHK:  if (stat.del_any) cmd.op = OP_DEL_RD;
      S_DEL_MOVE: cmd.op = OP_DEL_STEP;
      S_DEL_DONE: cmd.op = OP_DEL_DONE;
      S_COUNT:    if (!stat.cnt_done) cmd.op = OP_CNT_STEP;
      S_FREE:     if (!stat.free_done) cmd.op = OP_FREE_STEP;
      S_EMIT:     if (!stat.out_busy) cmd.op = OP_EMIT;
      default: ;
    endcase
  end

endmodule

### design/smt_dp.sv
// ----------------------------------------------------------------------------
// smt_dp
// Datapath: entry memory, search bounds, slot map, counters and result register.
// ----------------------------------------------------------------------------
module smt_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  smt_pkg::in_item_t  in_data,
  input  logic               out_ready,
  input  smt_pkg::cmd_t      cmd,
  output smt_pkg::stat_t     stat,
  output logic               out_valid,
  output smt_pkg::out_item_t out_data
);
  import smt_pkg::*;

  // entry memory, one read and one write port
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  entry_t           wr_data;

  logic [TABLE_DEPTH-1:0] slot_used_r;

  logic [2:0]        act_r;
  logic [KEY_W-1:0]  key_r;
  logic [7:0]        ptype_r;
  logic [TERM_W-1:0] term_r;
  logic [7:0]        flag_r;
  logic [15:0]       snum_r;

  logic [CNT_W-1:0] lo_r, hi_r, idx_r, fill_r, cnt_r;
  logic             found_r, pend_r;
  entry_t           res_r;
  logic [IDX_W-1:0] res_idx_r;
  logic [IDX_W-1:0] free_slot_r;
  logic             free_found_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  entry_t           mod_entry, new_entry;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];

  // modified and inserted entry contents
  always_comb begin
    mod_entry      = res_r;
    mod_entry.term = term_r;
    if (act_r == ACT_ADD) begin
      mod_entry.ptype = ptype_r;
      mod_entry.flag  = flag_r;
    end
    new_entry = '{key: key_r, ptype: ptype_r, term: term_r, flag: flag_r,
                  slot: snum_r[IDX_W-1:0]};
  end

  // memory port steering
  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    wr_en   = 1'b0;
    wr_data = rd_data_r;
    case (cmd.op)
      OP_SRCH_RD:  rd_addr = mid;
      OP_PROBE_RD: rd_addr = lo_r[IDX_W-1:0];
      OP_INS_RD:   rd_addr = IDX_W'(idx_r - CNT_W'(1));
      OP_INS_STEP: begin
        rd_addr = IDX_W'(idx_r - CNT_W'(2));
        wr_addr = idx_r[IDX_W-1:0];
        wr_en   = 1'b1;
      end
      OP_DEL_RD:   rd_addr = IDX_W'(idx_r + CNT_W'(1));
      OP_DEL_STEP: begin
        rd_addr = IDX_W'(idx_r + CNT_W'(2));
        wr_addr = idx_r[IDX_W-1:0];
        wr_en   = 1'b1;
      end
      OP_MODIFY: begin
        wr_addr = lo_r[IDX_W-1:0];
        wr_data = mod_entry;
        wr_en   = 1'b1;
      end
      OP_INS_PUT: begin
        wr_addr = lo_r[IDX_W-1:0];
        wr_data = new_entry;
        wr_en   = 1'b1;
      end
      OP_CNT_STEP: rd_addr = idx_r[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // request fields, latched at accept
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      act_r   <= in_data.action;
      key_r   <= in_data.meter_key;
      ptype_r <= in_data.protocol_type;
      term_r  <= in_data.terminal_addr;
      flag_r  <= in_data.success_flag;
      snum_r  <= in_data.slot_number;
    end
  end

  // search bounds, move index and scan state
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        lo_r         <= '0;
        hi_r         <= fill_r;
        cnt_r        <= '0;
        free_slot_r  <= '0;
        free_found_r <= 1'b0;
        found_r      <= 1'b0;
      end
      OP_SRCH_RD: idx_r <= CNT_W'(mid);
      OP_SRCH_UPD: begin
        if (rd_data_r.key < key_r) lo_r <= idx_r + CNT_W'(1);
        else                       hi_r <= idx_r;
      end
      OP_PROBE_CHK: begin
        found_r   <= (lo_r < fill_r) && (rd_data_r.key == key_r);
        res_r     <= rd_data_r;
        res_idx_r <= lo_r[IDX_W-1:0];
      end
      OP_MODIFY: res_r <= mod_entry;
      OP_INS_INIT: idx_r <= fill_r;
      OP_INS_STEP: idx_r <= idx_r - CNT_W'(1);
      OP_INS_PUT: begin
        res_r     <= new_entry;
        res_idx_r <= lo_r[IDX_W-1:0];
      end
      OP_DEL_INIT: idx_r <= lo_r;
      OP_DEL_STEP: idx_r <= idx_r + CNT_W'(1);
      OP_CNT_INIT: begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end
      OP_CNT_STEP: begin
        if (pend_r && rd_data_r.term == term_r) cnt_r <= cnt_r + CNT_W'(1);
        pend_r <= idx_r < fill_r;
        if (idx_r < fill_r) idx_r <= idx_r + CNT_W'(1);
      end
      OP_FREE_INIT: idx_r <= '0;
      OP_FREE_STEP: begin
        if (!slot_used_r[idx_r[IDX_W-1:0]]) begin
          free_found_r <= 1'b1;
          free_slot_r  <= idx_r[IDX_W-1:0];
        end
        idx_r <= idx_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // fill count and slot map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      slot_used_r <= '0;
    end else begin
      case (cmd.op)
        OP_INS_PUT: begin
          fill_r                               <= fill_r + CNT_W'(1);
          slot_used_r[snum_r[IDX_W-1:0]]       <= 1'b1;
        end
        OP_DEL_INIT: slot_used_r[res_r.slot]   <= 1'b0;
        OP_DEL_DONE: fill_r                    <= fill_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_data_r.status       <= cmd.res_status;
      out_data_r.entry_index  <= cmd.res_entry ? res_idx_r : '0;
      out_data_r.out_type     <= cmd.res_entry ? res_r.ptype : '0;
      out_data_r.out_terminal <= cmd.res_entry ? res_r.term : '0;
      out_data_r.out_flag     <= cmd.res_entry ? res_r.flag : '0;
      out_data_r.out_slot     <= cmd.res_entry ? res_r.slot : '0;
      out_data_r.match_count  <= cnt_r;
      out_data_r.free_slot    <= free_slot_r;
      out_data_r.free_found   <= free_found_r;
      out_data_r.entry_count  <= fill_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the sequencer
  always_comb begin
    stat.act       = act_r;
    stat.found     = found_r;
    stat.slot_bad  = snum_r >= 16'(TABLE_DEPTH);
    stat.full      = fill_r >= CNT_W'(TABLE_DEPTH);
    stat.srch_go   = lo_r < hi_r;
    stat.mv_any    = idx_r > lo_r;
    stat.mv_more   = idx_r > lo_r + CNT_W'(1);
    stat.del_any   = idx_r + CNT_W'(1) < fill_r;
    stat.del_more  = idx_r + CNT_W'(2) < fill_r;
    stat.cnt_done  = (idx_r >= fill_r) && !pend_r;
    stat.free_done = free_found_r || (idx_r == CNT_W'(TABLE_DEPTH));
    stat.out_busy  = out_valid_r && !out_ready;
  end

endmodule

### design/sorted_meter_table.sv
// ----------------------------------------------------------------------------
// sorted_meter_table
// Table of meter entries kept in ascending key order.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (valid/ready), one item per action: add or
// update, delete, lookup, set terminal, count a terminal's entries, or find
// the lowest free slot. Each request gives exactly one result item on out_ch.
// in_ch.ready is high only while the sequencer is idle and out of reset; one
// request is worked on at a time.
// Work per request: a binary search over the filled entries, then add of a
// new key moves one entry per cycle, delete likewise, count reads one entry
// per cycle and free slot tests one slot bit per cycle. The entry memory has
// one read and one write port, so one entry moves per cycle.
// Reset empties the table and marks every slot unused; no clearing pass.
// The result sits in an output register: a stalled receiver holds it there
// while the next request may still be accepted and worked up to its result.
// ----------------------------------------------------------------------------
module sorted_meter_table (
  input  logic      clk,
  input  logic      rst_n,
  smt_in_if.sink    in_ch,
  smt_out_if.source out_ch
);
  import smt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table storage and result register
  smt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

endmodule

### design/smt_checker.sv
// ----------------------------------------------------------------------------
// smt_checker
// Port-level checks on the sorted meter table, bound to the top level.
// ----------------------------------------------------------------------------
module smt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input smt_pkg::out_item_t out_data
);
  import smt_pkg::*;

  logic [1:0] pending_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without a request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == 9'(TABLE_DEPTH))
    else $error("table full reported below depth");

endmodule

bind sorted_meter_table smt_checker u_smt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

### test/tb_sorted_meter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted meter table: directed table of requests
// followed by random traffic of every action over a small key space, with
// bursty sender, stalling receiver and an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb;
  import smt_pkg::*;

  localparam int N_RANDOM = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smt_in_if  in_ch ();
  smt_out_if out_ch ();

  sorted_meter_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state: sorted table plus slot map
  logic [47:0] tbl_key  [TABLE_DEPTH];
  logic [7:0]  tbl_type [TABLE_DEPTH];
  logic [47:0] tbl_term [TABLE_DEPTH];
  logic [7:0]  tbl_flag [TABLE_DEPTH];
  logic [7:0]  tbl_slot [TABLE_DEPTH];
  logic        slot_taken [TABLE_DEPTH];
  int          tbl_fill;

  out_item_t pending_results [$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_sent = 0;
  bit        send_burst_on = 1'b0;

  // directed rows: request, typed expectation, and whether it is typed
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } row_t;

  function automatic out_item_t meter_table_step(in_item_t r);
    out_item_t o;
    int lo, hi, mid, pos, n;
    bit hit;
    o = '0;
    lo = 0;
    hi = tbl_fill;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_key[mid] < r.meter_key) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    hit = (pos < tbl_fill) && (tbl_key[pos] == r.meter_key);
    case (r.action)
      ACT_ADD: begin
        if (r.slot_number >= TABLE_DEPTH) begin
          o.status = ST_SLOT;
        end else if (hit) begin
          tbl_type[pos] = r.protocol_type;
          tbl_term[pos] = r.terminal_addr;
          tbl_flag[pos] = r.success_flag;
        end else if (tbl_fill >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (int i = tbl_fill; i > pos; i--) begin
            tbl_key[i]  = tbl_key[i-1];
            tbl_type[i] = tbl_type[i-1];
            tbl_term[i] = tbl_term[i-1];
            tbl_flag[i] = tbl_flag[i-1];
            tbl_slot[i] = tbl_slot[i-1];
          end
          tbl_key[pos]  = r.meter_key;
          tbl_type[pos] = r.protocol_type;
          tbl_term[pos] = r.terminal_addr;
          tbl_flag[pos] = r.success_flag;
          tbl_slot[pos] = r.slot_number[7:0];
          slot_taken[r.slot_number[7:0]] = 1'b1;
          tbl_fill++;
          hit = 1'b1;
        end
        if (o.status == ST_OK) begin
          o.entry_index = pos[7:0];
          o.out_type = tbl_type[pos];
          o.out_terminal = tbl_term[pos];
          o.out_flag = tbl_flag[pos];
          o.out_slot = tbl_slot[pos];
        end
      end
      ACT_DEL, ACT_LOOKUP, ACT_SETTERM: begin
        if (!hit) begin
          o.status = ST_NOTFOUND;
        end else begin
          if (r.action == ACT_SETTERM) tbl_term[pos] = r.terminal_addr;
          o.entry_index = pos[7:0];
          o.out_type = tbl_type[pos];
          o.out_terminal = tbl_term[pos];
          o.out_flag = tbl_flag[pos];
          o.out_slot = tbl_slot[pos];
          if (r.action == ACT_DEL) begin
            slot_taken[tbl_slot[pos]] = 1'b0;
            for (int i = pos; i + 1 < tbl_fill; i++) begin
              tbl_key[i]  = tbl_key[i+1];
              tbl_type[i] = tbl_type[i+1];
              tbl_term[i] = tbl_term[i+1];
              tbl_flag[i] = tbl_flag[i+1];
              tbl_slot[i] = tbl_slot[i+1];
            end
            tbl_fill--;
          end
        end
      end
      ACT_COUNT: begin
        n = 0;
        for (int i = 0; i < tbl_fill; i++)
          if (tbl_term[i] == r.terminal_addr) n++;
        o.match_count = n[8:0];
      end
      ACT_FREE: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!slot_taken[i]) begin
            o.free_slot = i[7:0];
            o.free_found = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    o.entry_count = tbl_fill[8:0];
    return o;
  endfunction

  function automatic in_item_t make_req(logic [2:0] act, logic [47:0] key,
                                        logic [7:0] ptype, logic [47:0] term,
                                        logic [7:0] flag, logic [15:0] slot);
    in_item_t r;
    r.action = act;
    r.meter_key = key;
    r.protocol_type = ptype;
    r.terminal_addr = term;
    r.success_flag = flag;
    r.slot_number = slot;
    return r;
  endfunction

  // drive one request; at the end of a burst valid drops for a random gap
  task automatic send_request(in_item_t r);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(meter_table_step(r));
    n_sent++;
    send_burst_on = ($urandom_range(0, 4) != 0);
    if (!send_burst_on) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet
  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic check_result(out_item_t w, out_item_t g);
    if (w.status != g.status) begin
      $error("status exp %0d got %0d", w.status, g.status); n_errors++;
    end
    if (w.entry_index != g.entry_index) begin
      $error("entry_index exp %0d got %0d", w.entry_index, g.entry_index); n_errors++;
    end
    if (w.out_type != g.out_type) begin
      $error("out_type exp %0h got %0h", w.out_type, g.out_type); n_errors++;
    end
    if (w.out_terminal != g.out_terminal) begin
      $error("out_terminal exp %0h got %0h", w.out_terminal, g.out_terminal); n_errors++;
    end
    if (w.out_flag != g.out_flag) begin
      $error("out_flag exp %0h got %0h", w.out_flag, g.out_flag); n_errors++;
    end
    if (w.out_slot != g.out_slot) begin
      $error("out_slot exp %0d got %0d", w.out_slot, g.out_slot); n_errors++;
    end
    if (w.match_count != g.match_count) begin
      $error("match_count exp %0d got %0d", w.match_count, g.match_count); n_errors++;
    end
    if (w.free_slot != g.free_slot) begin
      $error("free_slot exp %0d got %0d", w.free_slot, g.free_slot); n_errors++;
    end
    if (w.free_found != g.free_found) begin
      $error("free_found exp %0d got %0d", w.free_found, g.free_found); n_errors++;
    end
    if (w.entry_count != g.entry_count) begin
      $error("entry_count exp %0d got %0d", w.entry_count, g.entry_count); n_errors++;
    end
  endtask

  // receiver stall pattern and result checking
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 2) != 0);
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result item %p", out_ch.data);
          n_errors++;
        end else begin
          check_result(pending_results.pop_front(), out_ch.data);
        end
      end
    end
  end

  // random request over a small key space so hits are common
  function automatic in_item_t random_req(int key_span, int term_span);
    logic [2:0]  act;
    logic [47:0] key, term;
    logic [15:0] slot;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) act = ACT_ADD;
    else if (pick < 55) act = ACT_DEL;
    else if (pick < 70) act = ACT_LOOKUP;
    else if (pick < 80) act = ACT_SETTERM;
    else if (pick < 88) act = ACT_COUNT;
    else if (pick < 96) act = ACT_FREE;
    else act = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) == 0) key = 48'({$urandom, $urandom});
    else key = 48'(($urandom_range(0, key_span) * 48'h0101_0101_0101) ^ 48'h8000_0000_0000
               * $urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) term = 48'({$urandom, $urandom});
    else term = 48'($urandom_range(0, term_span)) << (8 * $urandom_range(0, 5));
    if ($urandom_range(0, 19) == 0) slot = 16'($urandom);
    else slot = 16'($urandom_range(0, TABLE_DEPTH - 1));
    return make_req(act, key, 8'($urandom), term, 8'($urandom), slot);
  endfunction

  initial begin
    row_t        rows [$];
    row_t        rw;
    out_item_t   w;
    int          wait_cycles;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tbl_fill = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) slot_taken[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: empty table, extremes, every action, error codes
    w = '0; w.status = ST_NOTFOUND;
    rows.push_back('{make_req(ACT_LOOKUP, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b1, w});
    rows.push_back('{make_req(ACT_DEL, 48'hFFFF_FFFF_FFFF, 8'h0, 48'h0, 8'h0, 16'h0), 1'b1, w});
    rows.push_back('{make_req(ACT_SETTERM, 48'h1, 8'h0, 48'h1, 8'h0, 16'h0), 1'b1, w});
    w = '0; w.free_found = 1'b1;
    rows.push_back('{make_req(ACT_FREE, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b1, w});
    w = '0; w.status = ST_SLOT;
    rows.push_back('{make_req(ACT_ADD, 48'h5, 8'h1, 48'h1, 8'h1, 16'hFFFF), 1'b1, w});
    rows.push_back('{make_req(ACT_ADD, 48'h5, 8'h1, 48'h1, 8'h1, 16'd256), 1'b1, w});
    w = '0;
    rows.push_back('{make_req(ACT_COUNT, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b1, w});
    rows.push_back('{make_req(3'd6, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b1, w});
    rows.push_back('{make_req(3'd7, 48'hFFFF_FFFF_FFFF, 8'hFF, 48'hFFFF_FFFF_FFFF,
                              8'hFF, 16'hFFFF), 1'b1, w});
    // first add of the extreme key, typed
    w = '0; w.out_type = 8'hFF; w.out_terminal = 48'hFFFF_FFFF_FFFF; w.out_flag = 8'hFF;
    w.out_slot = 8'hFF; w.entry_count = 9'd1;
    rows.push_back('{make_req(ACT_ADD, 48'hFFFF_FFFF_FFFF, 8'hFF, 48'hFFFF_FFFF_FFFF,
                              8'hFF, 16'd255), 1'b1, w});
    rows.push_back('{make_req(ACT_ADD, 48'h0, 8'h0, 48'h0, 8'h0, 16'd0), 1'b0, w});
    rows.push_back('{make_req(ACT_ADD, 48'h8000_0000_0000, 8'h5A, 48'hAAAA_AAAA_AAAA,
                              8'hA5, 16'd0), 1'b0, w});
    rows.push_back('{make_req(ACT_ADD, 48'h0, 8'h11, 48'h5555_5555_5555, 8'h22, 16'd7),
                     1'b0, w});
    rows.push_back('{make_req(ACT_SETTERM, 48'h8000_0000_0000, 8'h0, 48'h0, 8'h0, 16'h0),
                     1'b0, w});
    rows.push_back('{make_req(ACT_COUNT, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b0, w});
    rows.push_back('{make_req(ACT_FREE, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b0, w});
    rows.push_back('{make_req(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'h0, 48'h0, 8'h0, 16'h0),
                     1'b0, w});
    rows.push_back('{make_req(ACT_DEL, 48'h8000_0000_0000, 8'h0, 48'h0, 8'h0, 16'h0),
                     1'b0, w});
    rows.push_back('{make_req(ACT_FREE, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b0, w});
    rows.push_back('{make_req(ACT_DEL, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0), 1'b0, w});
    rows.push_back('{make_req(ACT_DEL, 48'hFFFF_FFFF_FFFF, 8'h0, 48'h0, 8'h0, 16'h0),
                     1'b0, w});

    foreach (rows[i]) begin
      rw = rows[i];
      send_request(rw.req);
      // swap in the typed expectation so it is checked independently
      if (rw.typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(rw.want);
      end
    end

    // fill the table to capacity, then hit the full-table case
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(make_req(ACT_ADD, 48'(i * 977 + 3), 8'(i), 48'(i % 4), 8'(i),
                            16'(i)));
    send_request(make_req(ACT_FREE, 48'h0, 8'h0, 48'h0, 8'h0, 16'h0));
    send_request(make_req(ACT_COUNT, 48'h0, 8'h0, 48'h1, 8'h0, 16'h0));
    send_request(make_req(ACT_ADD, 48'h1, 8'h0, 48'h0, 8'h0, 16'h0));
    send_request(make_req(ACT_ADD, 48'd3, 8'h77, 48'h9, 8'h66, 16'h1));

    // hold off until everything issued so far has come back
    release_input();
    while (pending_results.size() != 0) @(posedge clk);

    // drain the table with random deletes of existing keys
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(make_req(ACT_DEL, tbl_key[$urandom_range(0, tbl_fill - 1)],
                            8'h0, 48'h0, 8'h0, 16'h0));
    for (int i = tbl_fill; i > 0; i--)
      send_request(make_req(ACT_DEL, tbl_key[0], 8'h0, 48'h0, 8'h0, 16'h0));

    // random traffic
    for (int i = 0; i < N_RANDOM; i++)
      send_request(random_req(40, 5));
    release_input();

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);

    $display("tb: %0d requests sent, %0d results checked, table filled and drained",
             n_sent, n_results);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end
endmodule
